FILE: rtl/ssid_pkg.sv
`timescale 1ns / 1ps

package ssid_pkg;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_DELETE = 1'b1;

    localparam logic [1:0] ST_DONE     = 2'd0;
    localparam logic [1:0] ST_DUP      = 2'd1;
    localparam logic [1:0] ST_NOTFOUND = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    typedef struct packed {
        logic               opcode;
        logic signed [31:0] key;
    } cmd_word_t;

    typedef struct packed {
        logic [4:0]         entry_count;
        logic signed [31:0] element;
        logic               element_valid;
        logic               last;
        logic [1:0]         status;
    } result_word_t;

endpackage

FILE: rtl/sorted_set_insert_delete.sv
`timescale 1ns / 1ps

// Keeps up to CAPACITY distinct signed keys in ascending order in a single-port-write RAM with
// a registered read. A command word is taken when start is high and busy is low. The block
// first makes one read pass over the n held keys, finding the key's place and rippling the
// entries up or down behind the read pointer. It then reads the m keys held afterwards out
// again, giving one result word per held key on consecutive cycles, with result_strobe high
// for exactly one cycle per word and last set on the final one; an empty set gives one word
// with element_valid low and skips the read-out. The final word is shown in the same cycle
// as busy falls, when the next command may already be taken. The receiver cannot stall, so
// every word must be taken in the cycle it is shown.
module sorted_set_insert_delete
    import ssid_pkg::*;
#(
    parameter int CAPACITY = 16
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    output logic         busy,
    input  cmd_word_t    cmd,
    output logic         result_strobe,
    output result_word_t result
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    logic signed [31:0] key_ram [CAPACITY];

    logic [1:0]         state_reg, state_next;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic [CW-1:0]      ridx_reg, ridx_next;
    logic [CW-1:0]      pidx_reg, pidx_next;
    logic               pv_reg, pv_next;
    logic               hit_reg, hit_next;
    logic               pass_reg, pass_next;
    logic [1:0]         status_reg, status_next;
    logic               strobe_reg, strobe_next;
    logic               op_reg, op_next;
    logic signed [31:0] key_reg, key_next;
    logic signed [31:0] carry_reg, carry_next;
    logic signed [31:0] rd_data_reg;
    result_word_t       res_reg, res_next;

    logic               we;
    logic [AW-1:0]      waddr;
    logic signed [31:0] wdata;
    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    logic               full;
    logic [4:0]         cnt_ext;
    logic [CW-1:0]      cnt_dec;
    logic [CW-1:0]      pidx_dec;

    assign full     = (cnt_reg == CW'(CAPACITY));
    assign cnt_ext  = 5'(cnt_reg);
    assign cnt_dec  = cnt_reg - CW'(1);
    assign pidx_dec = pidx_reg - CW'(1);
    assign rd_addr  = ridx_reg[AW-1:0];

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        ridx_next   = ridx_reg;
        pidx_next   = pidx_reg;
        pv_next     = 1'b0;
        hit_next    = hit_reg;
        pass_next   = pass_reg;
        status_next = status_reg;
        strobe_next = 1'b0;
        op_next     = op_reg;
        key_next    = key_reg;
        carry_next  = carry_reg;
        res_next    = res_reg;
        we          = 1'b0;
        waddr       = '0;
        wdata       = '0;
        rd_en       = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next    = cmd.opcode;
                    key_next   = cmd.key;
                    ridx_next  = '0;
                    hit_next   = 1'b0;
                    pass_next  = 1'b0;
                    state_next = S_SCAN;
                end
            end

            S_SCAN:
            begin
                if (ridx_reg < cnt_reg)
                begin
                    rd_en     = 1'b1;
                    ridx_next = ridx_reg + CW'(1);
                end
                pv_next   = rd_en;
                pidx_next = ridx_reg;

                if (pv_reg)
                begin
                    if (op_reg == OP_INSERT)
                    begin
                        if (!pass_reg && !hit_reg)
                        begin
                            if (rd_data_reg == key_reg)
                            begin
                                hit_next = 1'b1;
                            end
                            else if (rd_data_reg > key_reg)
                            begin
                                pass_next  = 1'b1;
                                carry_next = rd_data_reg;
                                if (!full)
                                begin
                                    we    = 1'b1;
                                    waddr = pidx_reg[AW-1:0];
                                    wdata = key_reg;
                                end
                            end
                        end
                        else if (pass_reg && !hit_reg && !full)
                        begin
                            we         = 1'b1;
                            waddr      = pidx_reg[AW-1:0];
                            wdata      = carry_reg;
                            carry_next = rd_data_reg;
                        end
                    end
                    else
                    begin
                        if (!hit_reg && !pass_reg)
                        begin
                            if (rd_data_reg == key_reg)
                            begin
                                hit_next = 1'b1;
                            end
                            else if (rd_data_reg > key_reg)
                            begin
                                pass_next = 1'b1;
                            end
                        end
                        else if (hit_reg)
                        begin
                            we    = 1'b1;
                            waddr = pidx_dec[AW-1:0];
                            wdata = rd_data_reg;
                        end
                    end
                end

                if ((ridx_reg == cnt_reg) && !pv_reg)
                begin
                    ridx_next  = '0;
                    state_next = S_EMIT;
                    if (op_reg == OP_INSERT)
                    begin
                        if (hit_reg)
                        begin
                            status_next = ST_DUP;
                        end
                        else if (full)
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            we          = 1'b1;
                            waddr       = cnt_reg[AW-1:0];
                            wdata       = pass_reg ? carry_reg : key_reg;
                            cnt_next    = cnt_reg + CW'(1);
                            status_next = ST_DONE;
                        end
                    end
                    else
                    begin
                        if (hit_reg)
                        begin
                            cnt_next    = cnt_dec;
                            status_next = ST_DONE;
                        end
                        else
                        begin
                            status_next = ST_NOTFOUND;
                        end
                    end

                    if (cnt_next == '0)
                    begin
                        res_next.entry_count   = '0;
                        res_next.element       = '0;
                        res_next.element_valid = 1'b0;
                        res_next.last          = 1'b1;
                        res_next.status        = status_next;
                        strobe_next            = 1'b1;
                        state_next             = S_IDLE;
                    end
                end
            end

            S_EMIT:
            begin
                if (ridx_reg < cnt_reg)
                begin
                    rd_en     = 1'b1;
                    ridx_next = ridx_reg + CW'(1);
                end
                pv_next   = rd_en;
                pidx_next = ridx_reg;

                if (pv_reg)
                begin
                    res_next.entry_count   = cnt_ext;
                    res_next.element       = rd_data_reg;
                    res_next.element_valid = 1'b1;
                    res_next.last          = (pidx_reg == cnt_dec);
                    res_next.status        = status_reg;
                    strobe_next            = 1'b1;
                    if (pidx_reg == cnt_dec)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            key_ram[waddr] <= wdata;
        end
        if (rd_en)
        begin
            rd_data_reg <= key_ram[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            cnt_reg    <= '0;
            ridx_reg   <= '0;
            pidx_reg   <= '0;
            pv_reg     <= 1'b0;
            hit_reg    <= 1'b0;
            pass_reg   <= 1'b0;
            status_reg <= ST_DONE;
            strobe_reg <= 1'b0;
            op_reg     <= OP_INSERT;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            ridx_reg   <= ridx_next;
            pidx_reg   <= pidx_next;
            pv_reg     <= pv_next;
            hit_reg    <= hit_next;
            pass_reg   <= pass_next;
            status_reg <= status_next;
            strobe_reg <= strobe_next;
            op_reg     <= op_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        carry_reg <= carry_next;
        res_reg   <= res_next;
    end

    assign busy          = (state_reg != S_IDLE);
    assign result_strobe = strobe_reg;
    assign result        = res_reg;

endmodule

FILE: sim/set_contents_checker.sv
`timescale 1ns / 1ps

module set_contents_checker
    import ssid_pkg::*;
#(
    parameter int CAPACITY = 16
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic         busy,
    input  cmd_word_t    cmd,
    input  logic         result_strobe,
    input  result_word_t result,
    output int           mismatch_count,
    output int           words_due
);

    logic signed [31:0] set_keys [CAPACITY];
    int                 set_size;
    result_word_t       contents_due [$];

    task automatic apply_op(input cmd_word_t word);
        logic signed [31:0] k;
        int                 pos;
        bit                 found;
        logic [1:0]         outcome;
        result_word_t       w;
        k = word.key;
        pos = 0;
        while (pos < set_size && set_keys[pos] < k)
            pos++;
        found = (pos < set_size) && (set_keys[pos] == k);
        if (word.opcode == OP_INSERT)
        begin
            if (found)
                outcome = ST_DUP;
            else if (set_size >= CAPACITY)
                outcome = ST_FULL;
            else
            begin
                for (int i = set_size; i > pos; i--)
                    set_keys[i] = set_keys[i - 1];
                set_keys[pos] = k;
                set_size++;
                outcome = ST_DONE;
            end
        end
        else
        begin
            if (!found)
                outcome = ST_NOTFOUND;
            else
            begin
                for (int i = pos; i + 1 < set_size; i++)
                    set_keys[i] = set_keys[i + 1];
                set_size--;
                outcome = ST_DONE;
            end
        end
        if (set_size == 0)
        begin
            w.entry_count   = '0;
            w.element       = '0;
            w.element_valid = 1'b0;
            w.last          = 1'b1;
            w.status        = outcome;
            contents_due.push_back(w);
        end
        else
        begin
            for (int i = 0; i < set_size; i++)
            begin
                w.entry_count   = set_size[4:0];
                w.element       = set_keys[i];
                w.element_valid = 1'b1;
                w.last          = (i + 1 == set_size);
                w.status        = outcome;
                contents_due.push_back(w);
            end
        end
    endtask

    task automatic check_word(input result_word_t got);
        result_word_t want;
        if (contents_due.size() == 0)
        begin
            $error("result word with none expected: element %0d", got.element);
            mismatch_count++;
        end
        else
        begin
            want = contents_due.pop_front();
            if (got.entry_count !== want.entry_count)
            begin
                $error("entry_count: expected %0d, got %0d", want.entry_count, got.entry_count);
                mismatch_count++;
            end
            if (got.element !== want.element)
            begin
                $error("element: expected %0d, got %0d", want.element, got.element);
                mismatch_count++;
            end
            if (got.element_valid !== want.element_valid)
            begin
                $error("element_valid: expected %0b, got %0b",
                       want.element_valid, got.element_valid);
                mismatch_count++;
            end
            if (got.last !== want.last)
            begin
                $error("last: expected %0b, got %0b", want.last, got.last);
                mismatch_count++;
            end
            if (got.status !== want.status)
            begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                mismatch_count++;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_size = 0;
            contents_due.delete();
        end
        else
        begin
            if (result_strobe === 1'b1)
                check_word(result);
            if (start && busy === 1'b0)
                apply_op(cmd);
        end
        words_due = contents_due.size();
    end

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import ssid_pkg::*;

    localparam int CAPACITY    = 16;
    localparam int CYCLE_LIMIT = 200000;
    localparam int POOL_SIZE   = 20;

    logic         clk;
    logic         rst_n;
    logic         start;
    logic         busy;
    cmd_word_t    cmd;
    logic         result_strobe;
    result_word_t result;
    int           mismatch_count;
    int           words_due;
    int           cycle_count;
    bit           sender_idles;
    logic signed [31:0] key_pool [POOL_SIZE];

    sorted_set_insert_delete #(.CAPACITY(CAPACITY)) dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .cmd           (cmd),
        .result_strobe (result_strobe),
        .result        (result)
    );

    set_contents_checker #(.CAPACITY(CAPACITY)) checker_i
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .cmd            (cmd),
        .result_strobe  (result_strobe),
        .result         (result),
        .mismatch_count (mismatch_count),
        .words_due      (words_due)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // Called at a falling edge; returns at the falling edge after the word is taken.
    task automatic issue(input logic op, input logic signed [31:0] k);
        bit taken;
        while (sender_idles && $urandom_range(99) < 31)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start <= 1'b1;
        cmd   <= cmd_word_t'{opcode: op, key: k};
        forever
        begin
            taken = (busy == 1'b0);
            @(negedge clk);
            if (taken)
                break;
        end
    endtask

    task automatic wait_for_contents;
        start <= 1'b0;
        @(negedge clk);
        while (words_due != 0)
            @(negedge clk);
    endtask

    function automatic logic signed [31:0] pick_key();
        if ($urandom_range(99) < 75)
            return key_pool[$urandom_range(POOL_SIZE - 1)];
        return $urandom;
    endfunction

    initial
    begin
        bit filling;
        int phase_left;
        logic op;
        rst_n        = 1'b0;
        start        = 1'b0;
        cmd          = '0;
        sender_idles = 1'b1;
        key_pool[0] = 32'sh7fffffff;
        key_pool[1] = 32'sh80000000;
        key_pool[2] = 32'sd0;
        key_pool[3] = -32'sd1;
        key_pool[4] = 32'sd1;
        for (int i = 5; i < POOL_SIZE; i++)
            key_pool[i] = $urandom;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        issue(OP_DELETE, 32'sd5);
        issue(OP_INSERT, 32'sh7fffffff);
        issue(OP_INSERT, 32'sh80000000);
        issue(OP_INSERT, 32'sd0);
        issue(OP_INSERT, -32'sd1);
        issue(OP_INSERT, 32'sd1);
        issue(OP_INSERT, 32'sd0);
        issue(OP_DELETE, 32'sd5);
        issue(OP_DELETE, 32'sd0);
        for (int i = 0; i < 12; i++)
            issue(OP_INSERT, i * 1000 - 6000);
        issue(OP_INSERT, 32'sd77);
        issue(OP_INSERT, 32'sh80000000);
        issue(OP_DELETE, 32'sh7fffffff);
        issue(OP_DELETE, 32'sh80000000);
        wait_for_contents();

        filling = 1'b0;
        phase_left = 0;
        for (int n = 0; n < 100; n++)
        begin
            if (phase_left == 0)
            begin
                filling = ~filling;
                phase_left = $urandom_range(25, 10);
            end
            phase_left--;
            sender_idles = !(n >= 40 && n < 60);
            if (filling)
                op = ($urandom_range(99) < 80) ? OP_INSERT : OP_DELETE;
            else
                op = ($urandom_range(99) < 80) ? OP_DELETE : OP_INSERT;
            issue(op, pick_key());
            if ($urandom_range(99) < 5)
                wait_for_contents();
        end

        wait_for_contents();
        repeat (50) @(negedge clk);
        if (mismatch_count == 0 && words_due == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
